// ===== hw/rtl/dtt_pkg.sv =====
// Package for the deadline timer table: request/result structs, codes, sizes.
// Used by every module of the block; depends on nothing.
package dtt_pkg;
	localparam int NUM_TIMERS_DEF = 16;
	localparam int TIME_BITS_DEF = 48;
	localparam int ID_W = 4;
	localparam int NOW_W = 48;
	localparam int IVAL_W = 32;

	localparam logic [2:0] REQ_ADD = 3'd0;
	localparam logic [2:0] REQ_CANCEL = 3'd1;
	localparam logic [2:0] REQ_REFRESH = 3'd2;
	localparam logic [2:0] REQ_RESET = 3'd3;
	localparam logic [2:0] REQ_EXPIRE = 3'd4;
	localparam logic [2:0] REQ_QUERY = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INACTIVE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NONE = 2'd3;

	typedef struct packed {
		logic [2:0] req_type;
		logic [NOW_W-1:0] now_ms;
		logic [IVAL_W-1:0] interval_ms;
		logic recurring;
		logic [ID_W-1:0] timer_id;
		logic restart_now;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ID_W-1:0] slot_id;
		logic [NOW_W-1:0] remaining_ms;
		logic none_pending;
		logic front_insert;
		logic last;
	} rsp_t;
endpackage

// ===== hw/rtl/dtt_cmp.sv =====
// Shared ordering comparator: (deadline, slot) of a candidate against the best or the new timer.
// Depends on dtt_pkg.
module dtt_cmp #(
	parameter int TB = dtt_pkg::TIME_BITS_DEF,
	parameter int IW = 4
) (
	input logic [TB-1:0] dl_a,
	input logic [IW-1:0] id_a,
	input logic [TB-1:0] dl_b,
	input logic [IW-1:0] id_b,
	output logic a_first
);
	import dtt_pkg::*;
	assign a_first = (dl_a < dl_b) || (dl_a == dl_b && id_a < id_b);
endmodule

// ===== hw/rtl/deadline_timer_table_top.sv =====
// Deadline timer table top: sequencer, slot storage, shared compare; uses dtt_pkg, dtt_cmp.
// Cancel/refresh/reset/query/full add: scan, then action; add also rescans for the front check.
// Expire: scan and action, then a retire step and a rescan for each due timer.
// busy holds until the last result is on the ports; the next item may enter as it is taken.
// Results cannot be stalled; one item is in flight at a time.
// Reset clears active bits and the front flag; slot payload is undefined until written.
module deadline_timer_table_top #(
	parameter int NUM_TIMERS = dtt_pkg::NUM_TIMERS_DEF,
	parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input dtt_pkg::req_t req,
	output logic rsp_valid,
	output dtt_pkg::rsp_t rsp
);
	import dtt_pkg::*;
	localparam int SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CW = $clog2(NUM_TIMERS + 1);
	localparam logic [TIME_BITS-1:0] TMAX = '1;
	localparam logic [CW-1:0] LAST_IDX = CW'(NUM_TIMERS - 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_ACT = 5'b00100,
		S_ADDF = 5'b01000,
		S_OUT = 5'b10000
	} state_t;

	state_t state_q;
	req_t req_q;
	logic [NUM_TIMERS-1:0] act_q, rec_q, taken_q;
	logic [IVAL_W-1:0] ival_q [NUM_TIMERS];
	logic [TIME_BITS-1:0] dl_q [NUM_TIMERS];
	logic front_q;
	logic [CW-1:0] idx_q;
	logic found_q, free_found_q, front_ok_q, any_out_q;
	logic [SW-1:0] best_q, free_q;
	logic [TIME_BITS-1:0] best_dl_q;
	rsp_t rsp_q;
	logic rsp_v_q;

	logic [SW-1:0] ci;
	logic [TIME_BITS-1:0] now_t, sum_a, sum_r, cand_dl, cmp_dl;
	logic [IVAL_W-1:0] sum_b;
	logic [TIME_BITS:0] sum_w;
	logic a_first, cand_ok, id_ok;
	logic [SW-1:0] tid;
	logic front_blk, front_hit;
	rsp_t rsp_d;
	logic rsp_v_d;

	function automatic rsp_t mk(logic [1:0] st);
		rsp_t r;
		r = '0;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	assign ci = idx_q[SW-1:0];
	assign now_t = TIME_BITS'(req_q.now_ms);
	assign id_ok = {{(32-ID_W){1'b0}}, req_q.timer_id} < 32'(NUM_TIMERS);
	assign tid = SW'(req_q.timer_id);
	assign cand_dl = dl_q[ci];
	assign cmp_dl = (state_q == S_ADDF) ? sum_r : best_dl_q;

	dtt_cmp #(.TB(TIME_BITS), .IW(SW)) u_cmp (
		.dl_a(cand_dl), .id_a(ci),
		.dl_b(cmp_dl), .id_b((state_q == S_ADDF) ? free_q : best_q),
		.a_first(a_first)
	);

	// shared saturating adder
	always_comb begin
		sum_a = now_t;
		sum_b = req_q.interval_ms;
		if (state_q == S_OUT || (req_q.req_type == REQ_REFRESH)) sum_b = ival_q[tid];
		if (state_q == S_OUT) sum_b = ival_q[best_q];
		if (req_q.req_type == REQ_RESET && !req_q.restart_now)
			sum_a = (dl_q[tid] >= TIME_BITS'(ival_q[tid])) ?
				dl_q[tid] - TIME_BITS'(ival_q[tid]) : '0;
		sum_w = {1'b0, sum_a} + (TIME_BITS+1)'(sum_b);
		sum_r = sum_w[TIME_BITS] ? TMAX : sum_w[TIME_BITS-1:0];
	end

	always_comb begin
		cand_ok = act_q[ci] && !taken_q[ci];
		if (req_q.req_type == REQ_EXPIRE) cand_ok = cand_ok && cand_dl <= now_t;
	end

	assign front_blk = act_q[ci] && ci != free_q && a_first;
	assign front_hit = front_ok_q && !front_q && !front_blk;

	assign busy = state_q != S_IDLE;
	assign rsp_valid = rsp_v_q;
	assign rsp = rsp_q;

	// next result; an expire holds each due slot until the following scan sets last
	always_comb begin
		rsp_v_d = 1'b0;
		rsp_d = rsp_q;
		case (state_q)
			S_ACT: begin
				rsp_v_d = 1'b1;
				case (req_q.req_type)
					REQ_ADD: begin
						rsp_d = mk(ST_FULL);
						rsp_v_d = !free_found_q;
					end
					REQ_CANCEL, REQ_REFRESH: begin
						rsp_d = (!id_ok || !act_q[tid]) ? mk(ST_INACTIVE) : mk(ST_OK);
					end
					REQ_RESET: begin
						rsp_d = mk(ST_OK);
						if (!id_ok) rsp_d = mk(ST_INACTIVE);
						else if (ival_q[tid] == req_q.interval_ms && !req_q.restart_now)
							rsp_d = mk(ST_OK);
						else if (!act_q[tid]) rsp_d = mk(ST_INACTIVE);
					end
					REQ_EXPIRE: begin
						if (any_out_q) rsp_d.last = !found_q;
						else if (found_q) rsp_v_d = 1'b0;
						else rsp_d = mk(ST_NONE);
					end
					REQ_QUERY: begin
						rsp_d = mk(ST_OK);
						if (!found_q) begin
							rsp_d.none_pending = 1'b1;
							rsp_d.remaining_ms = '1;
						end else
							rsp_d.remaining_ms = NOW_W'((now_t >= best_dl_q) ?
								'0 : best_dl_q - now_t);
					end
					default: rsp_d = mk(ST_INACTIVE);
				endcase
			end
			S_ADDF: begin
				if (idx_q == LAST_IDX) begin
					rsp_v_d = 1'b1;
					rsp_d = mk(ST_OK);
					rsp_d.slot_id = ID_W'(free_q);
					rsp_d.front_insert = front_hit;
				end
			end
			S_OUT: begin
				rsp_d = '0;
				rsp_d.slot_id = ID_W'(best_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			req_q <= '0;
			act_q <= '0;
			front_q <= 1'b0;
			rsp_v_q <= 1'b0;
			rsp_q <= '0;
			idx_q <= '0;
			taken_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			any_out_q <= 1'b0;
			front_ok_q <= 1'b0;
			best_q <= '0;
			free_q <= '0;
			best_dl_q <= '0;
		end else begin
			rsp_v_q <= rsp_v_d;
			rsp_q <= rsp_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						idx_q <= '0;
						taken_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						any_out_q <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// find lowest free slot or the earliest eligible slot
					if (req_q.req_type == REQ_ADD) begin
						if (!act_q[ci] && !free_found_q) begin
							free_found_q <= 1'b1;
							free_q <= ci;
						end
					end else if (cand_ok && (!found_q || a_first)) begin
						found_q <= 1'b1;
						best_q <= ci;
						best_dl_q <= cand_dl;
					end
					if (idx_q == LAST_IDX) begin
						idx_q <= '0;
						state_q <= S_ACT;
					end else idx_q <= idx_q + 1'b1;
				end
				S_ACT: begin
					case (req_q.req_type)
						REQ_ADD: begin
							if (free_found_q) begin
								front_ok_q <= 1'b1;
								state_q <= S_ADDF;
							end else state_q <= S_IDLE;
						end
						REQ_CANCEL: begin
							if (id_ok && act_q[tid]) act_q[tid] <= 1'b0;
							state_q <= S_IDLE;
						end
						REQ_EXPIRE: begin
							state_q <= found_q ? S_OUT : S_IDLE;
						end
						REQ_QUERY: begin
							front_q <= 1'b0;
							state_q <= S_IDLE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_ADDF: begin
					// new timer is front unless the front flag is set or another active slot orders first
					if (idx_q == LAST_IDX) begin
						act_q[free_q] <= 1'b1;
						if (front_hit) front_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						if (front_blk) front_ok_q <= 1'b0;
						idx_q <= idx_q + 1'b1;
					end
				end
				S_OUT: begin
					// retire one due slot (re-armed if recurring) and rescan for the next
					taken_q[best_q] <= 1'b1;
					if (!rec_q[best_q]) act_q[best_q] <= 1'b0;
					any_out_q <= 1'b1;
					found_q <= 1'b0;
					idx_q <= '0;
					state_q <= S_SCAN;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_ACT) begin
			case (req_q.req_type)
				REQ_ADD: begin
					if (free_found_q) begin
						rec_q[free_q] <= req_q.recurring;
						ival_q[free_q] <= req_q.interval_ms;
						dl_q[free_q] <= sum_r;
					end
				end
				REQ_REFRESH: begin
					if (id_ok && act_q[tid]) dl_q[tid] <= sum_r;
				end
				REQ_RESET: begin
					if (id_ok && act_q[tid] &&
						!(ival_q[tid] == req_q.interval_ms && !req_q.restart_now)) begin
						ival_q[tid] <= req_q.interval_ms;
						dl_q[tid] <= sum_r;
					end
				end
				default: ;
			endcase
		end else if (state_q == S_OUT && rec_q[best_q]) dl_q[best_q] <= sum_r;
	end
endmodule

// ===== hw/rtl/dtt_checker.sv =====
// Port-level checker for the deadline timer table, bound to the top level.
// Depends on dtt_pkg.
module dtt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic rsp_valid,
	input dtt_pkg::rsp_t rsp
);
	import dtt_pkg::*;
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");
	a_rsp_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> $past(busy)) else $error("result without item");
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.last |-> !busy) else $error("busy after last");
	a_ok_front: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.front_insert |-> rsp.status == ST_OK) else $error("front bad");
endmodule

bind deadline_timer_table_top dtt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
	.rsp_valid(rsp_valid), .rsp(rsp)
);
